/* sv/mms_pkg.sv */
// ----------------------------------------------------------------------------
// mms_pkg
// Shared widths, types and helpers of the masked marginal sum block.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int unsigned POSITIONS    = 8;
  localparam int unsigned MAX_ALPHABET = 4;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned RADIX_W = 3;
  localparam int unsigned DIGIT_W = $clog2(MAX_ALPHABET);
  localparam int unsigned RANK_W  = $clog2(POSITIONS);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_WORD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_MIN    = 3'd2;
  localparam logic [RADIX_W-1:0] RADIX_BINARY = 3'd2;
  localparam logic [RADIX_W-1:0] RADIX_TERNARY = 3'd3;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(MAX_ALPHABET);

  typedef logic [DIGIT_W-1:0]                digit_t;
  typedef digit_t [POSITIONS-1:0]            digits_t;

  // Control of one processing step in the accumulate stage.
  typedef struct packed {
    logic go;
    logic last;
  } step_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] a);
    logic [RADIX_W-1:0] r;
    r = a;
    if (a < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (a > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

  function automatic longint unsigned pow3(input int unsigned k);
    longint unsigned p;
    p = 1;
    for (int unsigned j = 0; j < k; j++) begin
      p = p * 3;
    end
    return p;
  endfunction

endpackage

/* sv/mms_pattern_dec.sv */
// ----------------------------------------------------------------------------
// mms_pattern_dec
// Registered decoder of the pattern letters from fixed_word and position_mask.
// ----------------------------------------------------------------------------
module mms_pattern_dec (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mms_pkg::RADIX_W-1:0]       radix_i,
  input  logic [mms_pkg::MASK_W-1:0]        mask_i,
  input  logic [mms_pkg::WORD_W-1:0]        word_i,
  output mms_pkg::digits_t                  pattern_o
);
  import mms_pkg::*;

  logic [WORD_W-1:0] quot [POSITIONS];
  digits_t           raw;
  digits_t           pat_d;
  digits_t           pat_q;

  // Remainder by three: base-4 digits sum to the same residue.
  function automatic digit_t mod3(input logic [WORD_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int j = 0; j < WORD_W / 2; j++) begin
      s = s + 5'(v[2*j +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return digit_t'(t);
  endfunction

  // Each quotient word / 3^k is a multiply by a rounded-up reciprocal,
  // exact for every 16-bit word.
  for (genvar k = 0; k < POSITIONS; k++) begin : g_quot
    localparam longint unsigned Div   = pow3(k);
    localparam int unsigned     Shift = WORD_W + $clog2(Div);
    localparam longint unsigned Recip = ((64'd1 << Shift) + Div - 1) / Div;
    logic [63:0] prod;
    assign prod    = 64'(word_i) * 64'(Recip);
    assign quot[k] = WORD_W'(prod >> Shift);
  end

  always_comb begin
    for (int k = 0; k < POSITIONS; k++) begin
      unique case (radix_i)
        RADIX_BINARY:  raw[k] = digit_t'(word_i[k]);
        RADIX_TERNARY: raw[k] = mod3(quot[k]);
        default:       raw[k] = word_i[DIGIT_W*k +: DIGIT_W];
      endcase
    end
  end

  // Masked positions take pattern digits in ascending order.
  always_comb begin
    logic [RANK_W:0] rank;
    rank = '0;
    for (int i = 0; i < POSITIONS; i++) begin
      if (mask_i[i]) begin
        pat_d[i] = raw[rank[RANK_W-1:0]];
        rank     = rank + 1'b1;
      end else begin
        pat_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else begin
      pat_q <= pat_d;
    end
  end

  assign pattern_o = pat_q;

endmodule

/* sv/mms_index_counter.sv */
// ----------------------------------------------------------------------------
// mms_index_counter
// Mixed-radix index counter with pattern latch and match detection.
// ----------------------------------------------------------------------------
module mms_index_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mms_pkg::step_t                    step_i,
  input  logic [mms_pkg::RADIX_W-1:0]       radix_i,
  input  logic [mms_pkg::MASK_W-1:0]        mask_i,
  input  mms_pkg::digits_t                  pattern_dec_i,
  output logic                              match_o
);
  import mms_pkg::*;

  digits_t idx_q, idx_d, adv;
  digits_t pat_q, pat_d;
  digits_t pat_now;
  logic    at_zero;

  assign at_zero = (idx_q == '0);
  // The pattern is taken afresh at the first entry of every wrap.
  assign pat_now = at_zero ? pattern_dec_i : pat_q;

  always_comb begin
    match_o = 1'b1;
    for (int i = 0; i < POSITIONS; i++) begin
      if (mask_i[i] && (idx_q[i] != pat_now[i])) begin
        match_o = 1'b0;
      end
    end
  end

  always_comb begin
    logic                carry;
    logic [RADIX_W-1:0]  d;
    carry = 1'b1;
    adv   = idx_q;
    for (int i = 0; i < POSITIONS; i++) begin
      d = RADIX_W'(idx_q[i]) + 1'b1;
      if (carry) begin
        if (d < radix_i) begin
          adv[i] = DIGIT_W'(d);
          carry  = 1'b0;
        end else begin
          adv[i] = '0;
        end
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    pat_d = pat_q;
    if (step_i.go) begin
      idx_d = step_i.last ? '0 : adv;
      if (at_zero) begin
        pat_d = pattern_dec_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pat_q <= '0;
    end else begin
      idx_q <= idx_d;
      pat_q <= pat_d;
    end
  end

endmodule

/* sv/mms_accum.sv */
// ----------------------------------------------------------------------------
// mms_accum
// Saturating accumulator of matching entries and their count.
// ----------------------------------------------------------------------------
module mms_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mms_pkg::step_t                    step_i,
  input  logic                              match_i,
  input  logic [mms_pkg::VALUE_W-1:0]       value_i,
  output logic [mms_pkg::SUM_W-1:0]         fin_sum_o,
  output logic [mms_pkg::COUNT_W-1:0]       fin_count_o,
  output logic                              fin_ovf_o
);
  import mms_pkg::*;

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [SUM_W:0]     add;

  assign add = {1'b0, sum_q} + (SUM_W + 1)'(value_i);

  // Running totals including the entry now in the stage when it matches.
  always_comb begin
    fin_sum_o   = sum_q;
    fin_count_o = cnt_q;
    fin_ovf_o   = ovf_q;
    if (match_i) begin
      fin_sum_o = add[SUM_W] ? '1 : add[SUM_W-1:0];
      fin_ovf_o = ovf_q | add[SUM_W];
      if (cnt_q != '1) begin
        fin_count_o = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (step_i.go) begin
      if (step_i.last) begin
        sum_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        sum_d = fin_sum_o;
        cnt_d = fin_count_o;
        ovf_d = fin_ovf_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

/* sv/masked_marginal_sum.sv */
// ----------------------------------------------------------------------------
// masked_marginal_sum
// Marginal sum of a streamed probability table over a masked letter pattern.
// ----------------------------------------------------------------------------
// The block takes one table entry per cycle while in_stall_o is low. Each
// entry is registered at the input; from the input register its index
// digits are compared with the pattern and its value is added to the
// saturating sum. The result of a pass is loaded into an output register
// when the entry marked last leaves the input register. The input stalls
// only when a last entry waits behind a result that is still held by
// the downstream stall. The pattern letters are decoded by a registered
// decoder (a reciprocal multiply for ternary words) from the configuration
// registers and latched at the first entry of each pass. Configuration
// writes are always ready.
module masked_marginal_sum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mms_pkg::VALUE_W-1:0]       prob_value_i,
  input  logic                              last_entry_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mms_pkg::SUM_W-1:0]         marginal_sum_o,
  output logic [mms_pkg::COUNT_W-1:0]       match_count_o,
  output logic                              sum_overflow_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mms_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mms_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mms_pkg::*;

  logic [MASK_W-1:0]  mask_q;
  logic [WORD_W-1:0]  word_q;
  logic [RADIX_W-1:0] alpha_q;
  logic [RADIX_W-1:0] radix;

  logic               in_vld_q;
  logic [VALUE_W-1:0] in_value_q;
  logic               in_last_q;
  logic               in_accept;

  logic               out_vld_q;
  logic [SUM_W-1:0]   out_sum_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               out_ovf_q;

  step_t              step;
  digits_t            pattern_dec;
  logic               match;
  logic [SUM_W-1:0]   fin_sum;
  logic [COUNT_W-1:0] fin_count;
  logic               fin_ovf;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      word_q  <= '0;
      alpha_q <= RADIX_MIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POSITION_MASK: mask_q  <= cfg_data_i[MASK_W-1:0];
        REG_FIXED_WORD:    word_q  <= cfg_data_i[WORD_W-1:0];
        REG_ALPHABET_SIZE: alpha_q <= cfg_data_i[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign radix = clamp_radix(alpha_q);

  // Only a last entry needs the result register, so only it can wait.
  assign step.last  = in_last_q;
  assign step.go    = in_vld_q && !(in_last_q && out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !step.go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (step.go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_value_q <= prob_value_i;
      in_last_q  <= last_entry_i;
    end
  end

  mms_pattern_dec u_pattern_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .radix_i   (radix),
    .mask_i    (mask_q),
    .word_i    (word_q),
    .pattern_o (pattern_dec)
  );

  mms_index_counter u_index_counter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .radix_i       (radix),
    .mask_i        (mask_q),
    .pattern_dec_i (pattern_dec),
    .match_o       (match)
  );

  mms_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .match_i     (match),
    .value_i     (in_value_q),
    .fin_sum_o   (fin_sum),
    .fin_count_o (fin_count),
    .fin_ovf_o   (fin_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step.go && step.last) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.go && step.last) begin
      out_sum_q <= fin_sum;
      out_cnt_q <= fin_count;
      out_ovf_q <= fin_ovf;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign marginal_sum_o = out_sum_q;
  assign match_count_o  = out_cnt_q;
  assign sum_overflow_o = out_ovf_q;

endmodule
